@@ hw/rtl/bipc_pkg.sv @@
package bipc_pkg;

	localparam int LAND_W      = 1;
	localparam int COUNT_W     = 21;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_W       = 11;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_COLS = 1'd1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// position class of one pixel, worked out when the beat is taken
	typedef struct packed {
		logic interior;  // judge the pixel above (row >= 2, not first or last column)
		logic border;    // pixel sits on the map edge
		logic last;      // last pixel of the frame
	} pix_flags_t;

endpackage

@@ hw/rtl/bipc_pos.sv @@
module bipc_pos
	import bipc_pkg::*;
#(
	parameter int MAX_ROWS = 1024,
	parameter int MAX_COLS = 1024,
	parameter int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	parameter int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	parameter int CCW = $clog2(MAX_COLS + 1),
	parameter int RCW = $clog2(MAX_ROWS + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           restart,
	input  logic           adv,
	input  logic [RCW-1:0] rows,
	input  logic [CCW-1:0] cols,
	output logic [CW-1:0]  col,
	output logic [CW-1:0]  col_next,
	output pix_flags_t     flags
);

	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [CCW-1:0] c_eff;
	logic [CCW-1:0] c_inc;
	logic [RCW-1:0] r_eff;
	logic [RCW-1:0] r_inc;
	logic           last_col;
	logic           last_row;

	always_comb begin
		c_eff    = (CCW'(col_q) >= cols) ? '0 : CCW'(col_q);
		r_eff    = (RCW'(row_q) >= rows) ? '0 : RCW'(row_q);
		c_inc    = c_eff + CCW'(1);
		r_inc    = r_eff + RCW'(1);
		last_col = (c_inc == cols);
		last_row = (r_inc == rows);
		flags.interior = (32'(r_eff) >= 32'd2) && (c_eff != '0) && (c_inc < cols);
		flags.border   = (r_eff == '0) || last_row || (c_eff == '0) || last_col;
		flags.last     = last_col && last_row;
		col      = CW'(c_eff);
		col_next = CW'(c_inc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (adv) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= flags.last ? '0 : RW'(r_inc);
			end else begin
				col_q <= CW'(c_inc);
				row_q <= RW'(r_eff);
			end
		end
	end

endmodule

@@ hw/rtl/bipc_linebuf.sv @@
module bipc_linebuf
	import bipc_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] rd_addr_next,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic          wr_above,
	input  logic          wr_two,
	output logic          above,
	output logic          right,
	output logic          up
);

	logic above_mem [DEPTH];
	logic two_mem   [DEPTH];

	logic above_rd_q;
	logic right_rd_q;
	logic up_rd_q;
	logic above_fw_q;
	logic right_fw_q;
	logic up_fw_q;
	logic above_fv_q;
	logic right_fv_q;
	logic up_fv_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			above_mem[wr_addr] <= wr_above;
			two_mem[wr_addr]   <= wr_two;
		end
	end

	// read ports; a write landing on the same edge is bypassed
	always_ff @(posedge clk) begin
		if (rd_en) begin
			above_rd_q <= above_mem[rd_addr];
			right_rd_q <= above_mem[rd_addr_next];
			up_rd_q    <= two_mem[rd_addr];
			above_fw_q <= wr_en && (wr_addr == rd_addr);
			right_fw_q <= wr_en && (wr_addr == rd_addr_next);
			up_fw_q    <= wr_en && (wr_addr == rd_addr);
			above_fv_q <= wr_above;
			right_fv_q <= wr_above;
			up_fv_q    <= wr_two;
		end
	end

	assign above = above_fw_q ? above_fv_q : above_rd_q;
	assign right = right_fw_q ? right_fv_q : right_rd_q;
	assign up    = up_fw_q    ? up_fv_q    : up_rd_q;

endmodule

@@ hw/rtl/binary_image_boundary_pixel_count_core.sv @@
// Path: an accepted beat is registered in the count stage, then a frame total in the output register.
// Throughput: one pixel per cycle; the only stall is a frame total waiting in the output
// register while the next frame's last pixel is ready to leave the count stage.
// Reset: arst_n clears position, count, window, map size (1 x 1) and valid flags at once.
// Line buffers are not cleared; every entry is written before it can affect a count.
module binary_image_boundary_pixel_count_core
	import bipc_pkg::*;
#(
	parameter int MAX_ROWS = 1024,
	parameter int MAX_COLS = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_W-1:0]       cfg_wdata,
	// pixel stream in
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] land, [7:1] zero
	// frame count out
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // [20:0] coast_count, [23:21] zero
);

	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CCW = $clog2(MAX_COLS + 1);
	localparam int RCW = $clog2(MAX_ROWS + 1);

	// map size, held already clamped to 1..MAX
	logic [RCW-1:0]     rows_q;
	logic [CCW-1:0]     cols_q;
	logic               restart;

	logic               accept;
	logic [CW-1:0]      col;
	logic [CW-1:0]      col_next;
	pix_flags_t         flags;

	// count stage
	logic               valid_s1;
	logic               land_s1;
	pix_flags_t         flags_s1;
	logic [CW-1:0]      col_s1;
	logic               go_s1;

	logic               above;
	logic               right;
	logic               up;
	logic               window_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W:0]   sum;
	logic [COUNT_W-1:0] count_next;
	logic               inc_inner;
	logic               inc_edge;

	logic               out_valid_q;
	logic [COUNT_W-1:0] out_count_q;

	// Any register write restarts the frame.
	assign restart = cfg_we && (cfg_idx == REG_MAP_ROWS || cfg_idx == REG_MAP_COLS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RCW'(1);
			cols_q <= CCW'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MAP_ROWS: begin
					if (cfg_wdata == '0)
						rows_q <= RCW'(1);
					else if (32'(cfg_wdata) > MAX_ROWS)
						rows_q <= RCW'(MAX_ROWS);
					else
						rows_q <= RCW'(cfg_wdata);
				end
				REG_MAP_COLS: begin
					if (cfg_wdata == '0)
						cols_q <= CCW'(1);
					else if (32'(cfg_wdata) > MAX_COLS)
						cols_q <= CCW'(MAX_COLS);
					else
						cols_q <= CCW'(cfg_wdata);
				end
				default: ;
			endcase
		end
	end

	// Advance the count stage unless it holds a frame total and the output is still full.
	assign go_s1    = valid_s1 && (!flags_s1.last || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || go_s1;
	assign accept   = s_tvalid && s_tready;

	// Pixel position and its class, decided as the beat is taken.
	bipc_pos #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart),
		.adv      (accept),
		.rows     (rows_q),
		.cols     (cols_q),
		.col      (col),
		.col_next (col_next),
		.flags    (flags)
	);

	// Two line buffers, read as the beat is taken, written as it leaves the count stage.
	bipc_linebuf #(
		.DEPTH (MAX_COLS)
	) u_linebuf (
		.clk          (clk),
		.rd_en        (accept),
		.rd_addr      (col),
		.rd_addr_next (col_next),
		.wr_en        (go_s1),
		.wr_addr      (col_s1),
		.wr_above     (land_s1),
		.wr_two       (above),
		.above        (above),
		.right        (right),
		.up           (up)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			land_s1  <= s_tdata[0];
			flags_s1 <= flags;
			col_s1   <= col;
		end
	end

	// The pixel above is judged once its lower neighbor arrives; edge pixels count at once.
	always_comb begin
		inc_inner  = flags_s1.interior && above && (!up || !window_q || !right || !land_s1);
		inc_edge   = land_s1 && flags_s1.border;
		sum        = {1'b0, count_q} + (COUNT_W+1)'(inc_inner) + (COUNT_W+1)'(inc_edge);
		count_next = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			window_q <= 1'b0;
		end else if (restart) begin
			count_q  <= '0;
			window_q <= 1'b0;
		end else if (go_s1) begin
			count_q  <= flags_s1.last ? '0 : count_next;
			window_q <= flags_s1.last ? 1'b0 : above;
		end
	end

	// Output register: hold the frame total until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && flags_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && flags_s1.last)
			out_count_q <= count_next;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_TDATA_W-COUNT_W)'(0), out_count_q};

	a_size_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(rows_q != '0) && (cols_q != '0))
		else $error("map size register holds zero");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !go_s1) |-> !s_tready)
		else $error("input taken while count stage is stalled");

	a_count_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && flags_s1.last && !restart) |=> (count_q == '0))
		else $error("count not cleared after frame end");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(go_s1 && flags_s1.last))
		else $error("result beat without a last pixel");

endmodule

@@ dv/tb.sv @@
module tb;
	import bipc_pkg::*;

	localparam int TB_MAX_ROWS  = 1024;
	localparam int TB_MAX_COLS  = 1024;
	localparam int DRAIN_CYCLES = 8;       // margin for the count stage and output register to drain
	localparam int RANDOM_PIXELS = 2000;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_SHOWN    = 10;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_idx   = REG_MAP_ROWS;
	logic [CFG_W-1:0]       cfg_wdata = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // [0] land, rest zero
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;          // [20:0] coast_count, rest zero

	binary_image_boundary_pixel_count_core #(
		.MAX_ROWS(TB_MAX_ROWS),
		.MAX_COLS(TB_MAX_COLS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Coast counter mirror: own copy of the line buffers, window, position
	// and running tally, stepped once per accepted pixel beat.
	// ------------------------------------------------------------------
	logic             row_prev   [TB_MAX_COLS];
	logic             row_prev2  [TB_MAX_COLS];
	logic             left_above;
	int unsigned      cur_row;
	int unsigned      cur_col;
	logic [COUNT_W-1:0] tally;
	logic [CFG_W-1:0] rows_reg;
	logic [CFG_W-1:0] cols_reg;

	// frame totals the block still owes us, oldest first
	logic [COUNT_W-1:0] coast_totals_q[$];

	// pixels waiting to go out on the input stream
	logic pixel_q[$];
	int   pushed_cnt   = 0;
	int   accepted_cnt = 0;
	int   mismatches   = 0;
	int   cycle_cnt    = 0;

	function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return 32'(v);
	endfunction

	function automatic int unsigned frame_pixels();
		return clamp_dim(rows_reg, TB_MAX_ROWS) * clamp_dim(cols_reg, TB_MAX_COLS);
	endfunction

	task automatic restart_tally();
		left_above = 1'b0;
		cur_row    = 0;
		cur_col    = 0;
		tally      = '0;
	endtask

	task automatic bump_tally();
		if (tally != COUNT_MAX) tally++;
	endtask

	// any register write restarts the frame; line buffers are kept
	task automatic apply_map_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		if (idx == REG_MAP_ROWS) rows_reg = val;
		else if (idx == REG_MAP_COLS) cols_reg = val;
		restart_tally();
	endtask

	task automatic track_pixel(input logic cur);
		int unsigned rows;
		int unsigned cols;
		int unsigned r;
		int unsigned c;
		logic        above;
		logic        up;
		logic        right_n;
		logic        border;
		rows = clamp_dim(rows_reg, TB_MAX_ROWS);
		cols = clamp_dim(cols_reg, TB_MAX_COLS);
		r = cur_row;
		c = cur_col;
		if (c >= cols) c = 0;
		if (r >= rows) r = 0;
		above = row_prev[c];
		// the pixel above is judged now that its lower neighbor is known
		if (r >= 2 && c >= 1 && c + 1 < cols && c + 1 < TB_MAX_COLS) begin
			up      = row_prev2[c];
			right_n = row_prev[c+1];
			if (above && (!up || !left_above || !right_n || !cur)) bump_tally();
		end
		border = (r == 0) || (r + 1 == rows) || (c == 0) || (c + 1 == cols);
		if (cur && border) bump_tally();
		row_prev2[c] = above;
		row_prev[c]  = cur;
		left_above   = above;
		if (c + 1 == cols && r + 1 == rows) begin
			coast_totals_q.push_back(tally);
			restart_tally();
		end else if (c + 1 == cols) begin
			cur_col = 0;
			cur_row = r + 1;
		end else begin
			cur_col = c + 1;
			cur_row = r;
		end
	endtask

	task automatic note_mismatch(input string what, input bit has_want,
			input logic [COUNT_W-1:0] want, input logic [COUNT_W-1:0] got);
		mismatches++;
		if (mismatches <= MAX_SHOWN) begin
			if (has_want) $display("mismatch: %s expected %0d got %0d", what, want, got);
			else $display("mismatch: %s got %0d", what, got);
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts of random length with random gaps. Hold the beat
	// until it is taken; step the mirror on every accepted beat.
	// ------------------------------------------------------------------
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				track_pixel(s_tdata[0]);
				accepted_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pixel_q.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {{(IN_TDATA_W-LAND_W){1'b0}}, pixel_q.pop_front()};
					burst_left--;
					if (burst_left <= 0) begin
						// new burst; a quarter of them run straight on with no gap
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: receiver alternates ready runs and stall runs of its own,
	// and checks every count beat against the oldest owed total.
	// ------------------------------------------------------------------
	int ready_left = 0;
	int stall_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (coast_totals_q.size() == 0) begin
					note_mismatch("count beat with no frame pending", 1'b0, '0,
						m_tdata[COUNT_W-1:0]);
				end else if (m_tdata[COUNT_W-1:0] !== coast_totals_q[0]) begin
					note_mismatch("coast_count", 1'b1, coast_totals_q[0], m_tdata[COUNT_W-1:0]);
					void'(coast_totals_q.pop_front());
				end else begin
					void'(coast_totals_q.pop_front());
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (ready_left > 0) begin
				ready_left--;
				m_tready <= 1'b1;
			end else begin
				ready_left = $urandom_range(1, 30);
				stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				m_tready <= (stall_left == 0);
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("FAIL binary_image_boundary_pixel_count_core");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		apply_map_size(idx, val);
	endtask

	// bit 0 of the pattern goes out first
	task automatic queue_bits(input logic [31:0] bits, input int n);
		@(negedge clk);
		for (int i = 0; i < n; i++) pixel_q.push_back(bits[i]);
		pushed_cnt += n;
	endtask

	task automatic queue_random(input int n, input int pct);
		@(negedge clk);
		for (int i = 0; i < n; i++) pixel_q.push_back($urandom_range(0, 99) < pct);
		pushed_cnt += n;
	endtask

	function automatic int pick_density();
		int sel;
		sel = $urandom_range(0, 5);
		if (sel == 0) return 0;
		if (sel == 1) return 100;
		return $urandom_range(10, 90);
	endfunction

	// wait for every beat to be taken and every total to arrive, then let the
	// pipeline drain so a trailing partial frame cannot race a register write
	task automatic wait_idle();
		while (accepted_cnt != pushed_cnt || coast_totals_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int random_pixels;
		int phase_no;
		int big_done;
		int n_frames;
		int fpx;
		int sel;

		for (int i = 0; i < TB_MAX_COLS; i++) begin
			row_prev[i]  = 1'b0;
			row_prev2[i] = 1'b0;
		end
		rows_reg = 1;
		cols_reg = 1;
		restart_tally();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: one-pixel map out of reset, land then water
		queue_bits(32'b1, 1);
		queue_bits(32'b0, 1);
		wait_idle();

		// 3x3 all land: the center has land on all four sides
		write_reg(REG_MAP_ROWS, 3);
		write_reg(REG_MAP_COLS, 3);
		queue_bits(32'h1ff, 9);
		wait_idle();

		// broken frame, then a write that restarts it, then a plus shape
		queue_bits(32'hf, 4);
		wait_idle();
		write_reg(REG_MAP_COLS, 3);
		queue_bits(32'b010111010, 9);
		wait_idle();

		// zero acts as one
		write_reg(REG_MAP_ROWS, 0);
		write_reg(REG_MAP_COLS, 0);
		queue_bits(32'b1, 1);
		wait_idle();

		// random phases: mostly small maps, a few at the size extremes
		random_pixels = 0;
		phase_no = 0;
		big_done = 0;
		while (random_pixels < RANDOM_PIXELS) begin
			if (phase_no % 10 == 5 && big_done < 3) begin
				case (big_done)
					0: begin
						write_reg(REG_MAP_ROWS,
							CFG_W'($urandom_range(TB_MAX_ROWS + 1, 2047)));
						write_reg(REG_MAP_COLS, 1);
					end
					1: begin
						write_reg(REG_MAP_COLS, 2047);
						write_reg(REG_MAP_ROWS, 1);
					end
					default: begin
						write_reg(REG_MAP_ROWS, 3);
						write_reg(REG_MAP_COLS, TB_MAX_COLS);
					end
				endcase
				big_done++;
				fpx = frame_pixels();
				queue_random(fpx, (big_done == 3) ? 90 : pick_density());
			end else begin
				sel = $urandom_range(0, 3);
				if (sel != 1)
					write_reg(REG_MAP_ROWS,
						CFG_W'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6)));
				if (sel != 0)
					write_reg(REG_MAP_COLS,
						CFG_W'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12)));
				fpx = frame_pixels();
				n_frames = $urandom_range(1, 4);
				for (int f = 0; f < n_frames; f++) queue_random(fpx, pick_density());
				random_pixels += n_frames * fpx;
				// now and then leave a frame unfinished before the next write
				if (fpx > 1 && $urandom_range(0, 5) == 0) begin
					queue_random($urandom_range(1, fpx - 1), pick_density());
				end
			end
			wait_idle();
			phase_no++;
		end

		if (mismatches == 0) begin
			$display("PASS binary_image_boundary_pixel_count_core");
		end else begin
			$display("FAIL binary_image_boundary_pixel_count_core");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/bipc_pkg.sv
hw/rtl/bipc_pos.sv
hw/rtl/bipc_linebuf.sv
hw/rtl/binary_image_boundary_pixel_count_core.sv
dv/tb.sv
